// ===== hdl/hba_pkg.sv =====
// Shared types and constants for the heap block allocator.
// No dependencies.
`default_nettype none
package hba_pkg;
    localparam int TABLE_DEPTH  = 64;
    localparam int IDX_W        = 7;
    localparam int SLOT_W       = 6;
    localparam logic [IDX_W-1:0] NULL_IDX = 7'd64;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_HEAP    = 3'd1;
    localparam logic [2:0] ST_ZERO_SIZE  = 3'd2;
    localparam logic [2:0] ST_BAD_ADDR   = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL = 3'd4;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NEXT  = 2'd3;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic CFG_FIT_MODE   = 1'b0;
    localparam logic CFG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic [15:0]      start;
        logic [15:0]      size;
        logic             is_free;
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] prev;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [6:0]  block_count;
        logic [1:0]  merges;
        logic        did_split;
        logic        grew;
        logic [15:0] granted_size;
        logic [15:0] data_addr;
        logic [2:0]  status;
    } result_t;
endpackage
`default_nettype wire

// ===== hdl/hba_ram.sv =====
// Block table memory: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none
module hba_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/heap_block_allocator_core.sv =====
// Heap block allocator: list walker and update sequencer around the block table RAM.
// Depends on hba_pkg and hba_ram.
// Allocate walks the block list; release walks it up to the matching block.
// One transaction in flight; the next is taken while the result waits in its register.
// Reset: async, active low; clears valid bits and list state, no clearing pass.
`default_nettype none
module heap_block_allocator_core
    import hba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // request_size, release_addr
    input  wire logic        s_tuser,   // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // status, data_addr, granted_size, grew, did_split,
                                        // merges, block_count, zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);
    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_WALK    = 5'd1;
    localparam logic [4:0] S_WALK_Q  = 5'd2;
    localparam logic [4:0] S_CHOSEN  = 5'd3;
    localparam logic [4:0] S_PICK_Q  = 5'd4;
    localparam logic [4:0] S_WR_E    = 5'd5;
    localparam logic [4:0] S_RWALK   = 5'd6;
    localparam logic [4:0] S_RWALK_Q = 5'd7;
    localparam logic [4:0] S_R_NX    = 5'd8;
    localparam logic [4:0] S_R_NX_Q  = 5'd9;
    localparam logic [4:0] S_R_PV    = 5'd10;
    localparam logic [4:0] S_R_PV_Q  = 5'd11;
    localparam logic [4:0] S_R_WR    = 5'd12;
    localparam logic [4:0] S_FIX_RD  = 5'd13;
    localparam logic [4:0] S_FIX_Q   = 5'd14;
    localparam logic [4:0] S_DONE    = 5'd15;

    logic [4:0]             state_reg, state_next;
    logic [1:0]             fit_mode_reg, fit_mode_next;
    logic [16:0]            heap_limit_reg, heap_limit_next;
    logic [IDX_W-1:0]       head_reg, head_next, tail_reg, tail_next, rover_reg, rover_next;
    logic [16:0]            top_reg, top_next;
    logic [TABLE_DEPTH-1:0] in_use_reg, in_use_next;
    logic [6:0]             count_reg, count_next;
    logic                   func_reg, func_next;
    logic [16:0]            size_reg, size_next;
    logic [15:0]            addr_reg, addr_next;
    logic [IDX_W-1:0]       cur_reg, cur_next, begin_reg, begin_next;
    logic                   phase_reg, phase_next;
    logic [IDX_W-1:0]       pick_reg, pick_next;
    logic [15:0]            pick_size_reg, pick_size_next;
    entry_t                 e_reg, e_next;
    logic [IDX_W-1:0]       ei_reg, ei_next;
    logic [IDX_W-1:0]       fix_idx_reg, fix_idx_next, fix_val_reg, fix_val_next;
    logic                   fix_prev_reg, fix_prev_next;
    logic [4:0]             fix_ret_reg, fix_ret_next;
    logic                   need_fix_reg, need_fix_next;
    result_t                res_reg, res_next, out_reg, out_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
    entry_t                 ram_wdata, q;
    logic [IDX_W-1:0]       slot_idx;
    logic                   in_acc;
    logic [17:0]            need_top, limit18;

    hba_ram #(.DATA_W(ENTRY_W), .ADDR_W(SLOT_W)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (q)
    );

    function automatic logic is_valid(input logic [IDX_W-1:0] i,
                                      input logic [TABLE_DEPTH-1:0] used);
        is_valid = !i[IDX_W-1] && used[i[SLOT_W-1:0]];
    endfunction

    always_comb
    begin
        slot_idx = NULL_IDX;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                slot_idx = IDX_W'(i);
            end
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, out_reg};
    assign need_top  = {1'b0, top_reg} + 18'd32 + {1'b0, size_reg};
    assign limit18   = (heap_limit_reg > 17'h10000) ? 18'h10000 : {1'b0, heap_limit_reg};

    always_comb
    begin
        state_next      = state_reg;
        fit_mode_next   = fit_mode_reg;
        heap_limit_next = heap_limit_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        rover_next      = rover_reg;
        top_next        = top_reg;
        in_use_next     = in_use_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        cur_next        = cur_reg;
        begin_next      = begin_reg;
        phase_next      = phase_reg;
        pick_next       = pick_reg;
        pick_size_next  = pick_size_reg;
        e_next          = e_reg;
        ei_next         = ei_reg;
        fix_idx_next    = fix_idx_reg;
        fix_val_next    = fix_val_reg;
        fix_prev_next   = fix_prev_reg;
        fix_ret_next    = fix_ret_reg;
        need_fix_next   = need_fix_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_waddr       = cur_reg[SLOT_W-1:0];
        ram_wdata       = e_reg;
        ram_raddr       = cur_reg[SLOT_W-1:0];

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FIT_MODE)
            begin
                fit_mode_next = cfg_data[1:0];
            end
            else
            begin
                heap_limit_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    func_next = s_tuser;
                    size_next = ({1'b0, s_tdata[15:0]} + 17'd3) & ~17'd3;
                    addr_next = s_tdata[31:16];
                    res_next  = '0;
                    pick_next = NULL_IDX;
                    phase_next = 1'b0;
                    if (s_tuser == FUNC_ALLOC)
                    begin
                        if (size_next == 17'd0)
                        begin
                            res_next.status = ST_ZERO_SIZE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (fit_mode_reg == FIT_NEXT && is_valid(rover_reg, in_use_reg))
                            begin
                                cur_next = rover_reg;
                            end
                            else
                            begin
                                cur_next = head_reg;
                            end
                            begin_next = cur_next;
                            state_next = S_WALK;
                        end
                    end
                    else if (s_tdata[31:16] == 16'd0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next   = head_reg;
                        state_next = S_RWALK;
                    end
                end
            end
            S_WALK:
            begin
                if (!is_valid(cur_reg, in_use_reg) || (phase_reg && cur_reg == begin_reg))
                begin
                    if (fit_mode_reg == FIT_NEXT && !phase_reg)
                    begin
                        phase_next = 1'b1;
                        cur_next   = head_reg;
                    end
                    else
                    begin
                        state_next = S_CHOSEN;
                    end
                end
                else
                begin
                    state_next = S_WALK_Q;
                end
            end
            S_WALK_Q:
            begin
                cur_next   = q.next;
                state_next = S_WALK;
                if (q.is_free && {1'b0, q.size} >= size_reg)
                begin
                    if (fit_mode_reg == FIT_FIRST || fit_mode_reg == FIT_NEXT)
                    begin
                        pick_next  = cur_reg;
                        state_next = S_CHOSEN;
                    end
                    else if (pick_reg == NULL_IDX
                             || (fit_mode_reg == FIT_BEST && q.size < pick_size_reg)
                             || (fit_mode_reg == FIT_WORST && q.size > pick_size_reg))
                    begin
                        pick_next      = cur_reg;
                        pick_size_next = q.size;
                    end
                end
            end
            S_CHOSEN:
            begin
                if (fit_mode_reg == FIT_NEXT)
                begin
                    rover_next = pick_reg;
                end
                if (pick_reg != NULL_IDX)
                begin
                    ram_raddr  = pick_reg[SLOT_W-1:0];
                    state_next = S_PICK_Q;
                end
                else if (need_top > limit18)
                begin
                    res_next.status = ST_NO_HEAP;
                    state_next = S_DONE;
                end
                else if (slot_idx == NULL_IDX)
                begin
                    res_next.status = ST_TABLE_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = slot_idx[SLOT_W-1:0];
                    ram_wdata.start   = top_reg[15:0];
                    ram_wdata.size    = size_reg[15:0];
                    ram_wdata.is_free = 1'b0;
                    ram_wdata.next    = NULL_IDX;
                    ram_wdata.prev    = tail_reg;
                    in_use_next[slot_idx[SLOT_W-1:0]] = 1'b1;
                    count_next = count_reg + 7'd1;
                    top_next   = need_top[16:0];
                    res_next.grew         = 1'b1;
                    res_next.data_addr    = top_reg[15:0] + 16'd32;
                    res_next.granted_size = size_reg[15:0];
                    tail_next = slot_idx;
                    if (is_valid(tail_reg, in_use_reg))
                    begin
                        fix_idx_next  = tail_reg;
                        fix_prev_next = 1'b0;
                        fix_val_next  = slot_idx;
                        fix_ret_next  = S_DONE;
                        state_next    = S_FIX_RD;
                    end
                    else
                    begin
                        head_next  = slot_idx;
                        state_next = S_DONE;
                    end
                end
            end
            S_PICK_Q:
            begin
                e_next         = q;
                e_next.is_free = 1'b0;
                ei_next        = pick_reg;
                need_fix_next  = 1'b0;
                res_next.data_addr    = q.start + 16'd32;
                res_next.granted_size = q.size;
                if ({2'b00, q.size} >= {1'b0, size_reg} + 18'd36 && slot_idx != NULL_IDX)
                begin
                    ram_we            = 1'b1;
                    ram_waddr         = slot_idx[SLOT_W-1:0];
                    ram_wdata.start   = q.start + 16'd32 + size_reg[15:0];
                    ram_wdata.size    = q.size - size_reg[15:0] - 16'd32;
                    ram_wdata.is_free = 1'b1;
                    ram_wdata.next    = q.next;
                    ram_wdata.prev    = pick_reg;
                    in_use_next[slot_idx[SLOT_W-1:0]] = 1'b1;
                    count_next  = count_reg + 7'd1;
                    e_next.size = size_reg[15:0];
                    e_next.next = slot_idx;
                    res_next.granted_size = size_reg[15:0];
                    res_next.did_split    = 1'b1;
                    if (is_valid(q.next, in_use_reg))
                    begin
                        need_fix_next = 1'b1;
                        fix_idx_next  = q.next;
                        fix_prev_next = 1'b1;
                        fix_val_next  = slot_idx;
                        fix_ret_next  = S_DONE;
                    end
                    else
                    begin
                        tail_next = slot_idx;
                    end
                end
                state_next = S_WR_E;
            end
            S_WR_E:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ei_reg[SLOT_W-1:0];
                ram_wdata  = e_reg;
                state_next = need_fix_reg ? S_FIX_RD : S_DONE;
            end
            S_RWALK:
            begin
                if (!is_valid(cur_reg, in_use_reg))
                begin
                    res_next.status = ST_BAD_ADDR;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RWALK_Q;
                end
            end
            S_RWALK_Q:
            begin
                if (!q.is_free && {1'b0, q.start} + 17'd32 == {1'b0, addr_reg})
                begin
                    e_next         = q;
                    e_next.is_free = 1'b1;
                    ei_next        = cur_reg;
                    state_next     = S_R_NX;
                end
                else
                begin
                    cur_next   = q.next;
                    state_next = S_RWALK;
                end
            end
            S_R_NX:
            begin
                ram_raddr = e_reg.next[SLOT_W-1:0];
                state_next = is_valid(e_reg.next, in_use_reg) ? S_R_NX_Q : S_R_PV;
            end
            S_R_NX_Q:
            begin
                state_next = S_R_PV;
                if (q.is_free)
                begin
                    e_next.size = e_reg.size + 16'd32 + q.size;
                    e_next.next = q.next;
                    if (tail_reg == e_reg.next)
                    begin
                        tail_next = ei_reg;
                    end
                    if (rover_reg == e_reg.next)
                    begin
                        rover_next = ei_reg;
                    end
                    in_use_next[e_reg.next[SLOT_W-1:0]] = 1'b0;
                    count_next = count_reg - 7'd1;
                    res_next.merges = res_reg.merges + 2'd1;
                    if (is_valid(q.next, in_use_reg))
                    begin
                        fix_idx_next  = q.next;
                        fix_prev_next = 1'b1;
                        fix_val_next  = ei_reg;
                        fix_ret_next  = S_R_PV;
                        state_next    = S_FIX_RD;
                    end
                end
            end
            S_R_PV:
            begin
                ram_raddr = e_reg.prev[SLOT_W-1:0];
                state_next = is_valid(e_reg.prev, in_use_reg) ? S_R_PV_Q : S_R_WR;
            end
            S_R_PV_Q:
            begin
                if (q.is_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = e_reg.prev[SLOT_W-1:0];
                    ram_wdata      = q;
                    ram_wdata.size = q.size + 16'd32 + e_reg.size;
                    ram_wdata.next = e_reg.next;
                    if (tail_reg == ei_reg)
                    begin
                        tail_next = e_reg.prev;
                    end
                    if (rover_reg == ei_reg)
                    begin
                        rover_next = e_reg.prev;
                    end
                    in_use_next[ei_reg[SLOT_W-1:0]] = 1'b0;
                    count_next = count_reg - 7'd1;
                    res_next.merges       = res_reg.merges + 2'd1;
                    res_next.granted_size = ram_wdata.size;
                    if (is_valid(e_reg.next, in_use_reg))
                    begin
                        fix_idx_next  = e_reg.next;
                        fix_prev_next = 1'b1;
                        fix_val_next  = e_reg.prev;
                        fix_ret_next  = S_DONE;
                        state_next    = S_FIX_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_R_WR;
                end
            end
            S_R_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ei_reg[SLOT_W-1:0];
                ram_wdata  = e_reg;
                res_next.granted_size = e_reg.size;
                state_next = S_DONE;
            end
            S_FIX_RD:
            begin
                ram_raddr  = fix_idx_reg[SLOT_W-1:0];
                state_next = S_FIX_Q;
            end
            S_FIX_Q:
            begin
                ram_we    = 1'b1;
                ram_waddr = fix_idx_reg[SLOT_W-1:0];
                ram_wdata = q;
                if (fix_prev_reg)
                begin
                    ram_wdata.prev = fix_val_reg;
                end
                else
                begin
                    ram_wdata.next = fix_val_reg;
                end
                state_next = fix_ret_reg;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next             = res_reg;
                    out_next.block_count = count_reg;
                    m_tvalid_next        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fit_mode_reg   <= FIT_FIRST;
            heap_limit_reg <= 17'h10000;
            head_reg       <= NULL_IDX;
            tail_reg       <= NULL_IDX;
            rover_reg      <= NULL_IDX;
            top_reg        <= '0;
            in_use_reg     <= '0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fit_mode_reg   <= fit_mode_next;
            heap_limit_reg <= heap_limit_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            rover_reg      <= rover_next;
            top_reg        <= top_next;
            in_use_reg     <= in_use_next;
            count_reg      <= count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        size_reg      <= size_next;
        addr_reg      <= addr_next;
        cur_reg       <= cur_next;
        begin_reg     <= begin_next;
        phase_reg     <= phase_next;
        pick_reg      <= pick_next;
        pick_size_reg <= pick_size_next;
        e_reg         <= e_next;
        ei_reg        <= ei_next;
        fix_idx_reg   <= fix_idx_next;
        fix_val_reg   <= fix_val_next;
        fix_prev_reg  <= fix_prev_next;
        fix_ret_reg   <= fix_ret_next;
        need_fix_reg  <= need_fix_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 7'($countones(in_use_reg)))
        else $error("block count out of step with valid bits");

    a_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_IDX) == (tail_reg == NULL_IDX))
        else $error("list head and tail disagree on empty");

    a_release_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && func_reg == FUNC_RELEASE) |=> $stable(top_reg))
        else $error("heap top moved during release");
endmodule
`default_nettype wire

// ===== bench/heap_block_allocator_core_tb.sv =====
// Testbench for heap_block_allocator_core: directed and random allocate/release traffic,
// checked against an in-bench model of the block list. Depends on hba_pkg and the core.
module heap_block_allocator_core_tb
    import hba_pkg::*;
();

    localparam int HDR = 32;
    localparam int NB  = 64;
    localparam int NUL = 64;
    localparam int LIMIT_CYCLES = 1500000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [16:0] cfg_data;

    heap_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // block table copy
    int unsigned blk_start [NB];
    int unsigned blk_size  [NB];
    bit          blk_free  [NB];
    int unsigned blk_next  [NB];
    int unsigned blk_prev  [NB];
    bit          blk_used  [NB];
    int unsigned head_idx, tail_idx, top_bytes, rover_idx;
    logic [1:0]  fit_sel;
    int unsigned limit_bytes;

    result_t     pending_results [$];
    int unsigned live_addrs [$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;
    longint      cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** heap_block_allocator_core: FAILED **");
            $finish;
        end
    end

    function automatic bit live(int unsigned i);
        return i < NUL && blk_used[i];
    endfunction

    function automatic int unsigned first_unused();
        for (int i = 0; i < NB; i++)
            if (!blk_used[i])
                return i;
        return NUL;
    endfunction

    function automatic int unsigned used_count();
        int unsigned n;
        n = 0;
        for (int i = 0; i < NB; i++)
            if (blk_used[i])
                n++;
        return n;
    endfunction

    function automatic bit can_take(int unsigned i, int unsigned sz);
        return blk_free[i] && blk_size[i] >= sz;
    endfunction

    function automatic int unsigned pick_block(int unsigned sz);
        int unsigned cur, pick, steps, begin_idx;
        pick = NUL;
        if (fit_sel == FIT_NEXT)
        begin
            begin_idx = live(rover_idx) ? rover_idx : head_idx;
            cur = begin_idx;
            steps = 0;
            while (live(cur) && steps < NUL)
            begin
                if (can_take(cur, sz))
                begin
                    pick = cur;
                    break;
                end
                cur = blk_next[cur];
                steps++;
            end
            if (pick == NUL)
            begin
                cur = head_idx;
                steps = 0;
                while (live(cur) && cur != begin_idx && steps < NUL)
                begin
                    if (can_take(cur, sz))
                    begin
                        pick = cur;
                        break;
                    end
                    cur = blk_next[cur];
                    steps++;
                end
            end
            rover_idx = pick;
            return pick;
        end
        cur = head_idx;
        steps = 0;
        while (live(cur) && steps < NUL)
        begin
            if (can_take(cur, sz))
            begin
                if (fit_sel == FIT_FIRST)
                    return cur;
                if (pick == NUL || (fit_sel == FIT_BEST && blk_size[cur] < blk_size[pick]) ||
                    (fit_sel == FIT_WORST && blk_size[cur] > blk_size[pick]))
                    pick = cur;
            end
            cur = blk_next[cur];
            steps++;
        end
        return pick;
    endfunction

    function automatic void fold_into(int unsigned a, int unsigned b);
        int unsigned after;
        after = blk_next[b];
        blk_size[a] += HDR + blk_size[b];
        blk_next[a] = after;
        if (live(after))
            blk_prev[after] = a;
        if (tail_idx == b)
            tail_idx = a;
        if (rover_idx == b)
            rover_idx = a;
        blk_used[b] = 1'b0;
    endfunction

    function automatic result_t heap_outcome(logic func, logic [15:0] req, logic [15:0] addr);
        result_t r;
        int unsigned sz, b, lim, slot, nb, after, cur, nx, pv;
        r = '0;
        if (func == FUNC_ALLOC)
        begin
            sz = (int'(req) + 3) & ~3;
            if (sz == 0)
                r.status = ST_ZERO_SIZE;
            else
            begin
                b = pick_block(sz);
                if (b == NUL)
                begin
                    lim = limit_bytes > 65536 ? 65536 : limit_bytes;
                    slot = first_unused();
                    if (top_bytes + HDR + sz > lim)
                        r.status = ST_NO_HEAP;
                    else if (slot == NUL)
                        r.status = ST_TABLE_FULL;
                    else
                    begin
                        blk_used[slot] = 1'b1;
                        blk_start[slot] = top_bytes;
                        blk_size[slot] = sz;
                        blk_free[slot] = 1'b0;
                        blk_next[slot] = NUL;
                        blk_prev[slot] = tail_idx;
                        if (live(tail_idx))
                            blk_next[tail_idx] = slot;
                        else
                            head_idx = slot;
                        tail_idx = slot;
                        top_bytes += HDR + sz;
                        r.grew = 1'b1;
                        b = slot;
                    end
                end
                else if (blk_size[b] >= sz + HDR + 4)
                begin
                    nb = first_unused();
                    if (nb != NUL)
                    begin
                        after = blk_next[b];
                        blk_used[nb] = 1'b1;
                        blk_start[nb] = blk_start[b] + HDR + sz;
                        blk_size[nb] = blk_size[b] - sz - HDR;
                        blk_free[nb] = 1'b1;
                        blk_next[nb] = after;
                        blk_prev[nb] = b;
                        if (live(after))
                            blk_prev[after] = nb;
                        else
                            tail_idx = nb;
                        blk_next[b] = nb;
                        blk_size[b] = sz;
                        r.did_split = 1'b1;
                    end
                end
                if (r.status == ST_OK && live(b))
                begin
                    blk_free[b] = 1'b0;
                    r.data_addr = 16'(blk_start[b] + HDR);
                    r.granted_size = 16'(blk_size[b]);
                end
            end
        end
        else if (addr != 0)
        begin
            cur = NUL;
            for (int i = 0; i < NB; i++)
                if (blk_used[i] && !blk_free[i] && blk_start[i] + HDR == addr)
                begin
                    cur = i;
                    break;
                end
            if (cur == NUL)
                r.status = ST_BAD_ADDR;
            else
            begin
                blk_free[cur] = 1'b1;
                nx = blk_next[cur];
                if (live(nx) && blk_free[nx])
                begin
                    fold_into(cur, nx);
                    r.merges++;
                end
                pv = blk_prev[cur];
                if (live(pv) && blk_free[pv])
                begin
                    fold_into(pv, cur);
                    cur = pv;
                    r.merges++;
                end
                r.granted_size = 16'(blk_size[cur]);
            end
        end
        r.block_count = 7'(used_count());
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_request(logic func, logic [15:0] req, logic [15:0] addr);
        result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {addr, req};
        do
            @(posedge clk);
        while (!s_tready);
        r = heap_outcome(func, req, addr);
        pending_results.push_back(r);
        if (func == FUNC_ALLOC && r.status == ST_OK)
            live_addrs.push_back(32'(r.data_addr));
        if (func == FUNC_RELEASE && r.status == ST_OK)
            foreach (live_addrs[i])
                if (live_addrs[i] == addr)
                begin
                    live_addrs.delete(i);
                    break;
                end
    endtask

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[45:0];
                if (pending_results.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.data_addr != want.data_addr)
                        report_mismatch("data_addr", got.data_addr, want.data_addr);
                    if (got.granted_size != want.granted_size)
                        report_mismatch("granted_size", got.granted_size, want.granted_size);
                    if (got.grew != want.grew)
                        report_mismatch("grew", got.grew, want.grew);
                    if (got.did_split != want.did_split)
                        report_mismatch("did_split", got.did_split, want.did_split);
                    if (got.merges != want.merges)
                        report_mismatch("merges", got.merges, want.merges);
                    if (got.block_count != want.block_count)
                        report_mismatch("block_count", got.block_count, want.block_count);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [16:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FIT_MODE)
            fit_sel = val[1:0];
        else
            limit_bytes = 32'(val);
    endtask

    function automatic logic [15:0] some_live_addr();
        if (live_addrs.size() == 0)
            return 16'd0;
        return 16'(live_addrs[$urandom_range(live_addrs.size() - 1)]);
    endfunction

    task automatic test_directed();
        send_request(FUNC_ALLOC, 16'd0, 16'hFFFF);
        send_request(FUNC_RELEASE, 16'hFFFF, 16'd0);
        send_request(FUNC_ALLOC, 16'd1, 16'd0);
        send_request(FUNC_ALLOC, 16'd100, 16'd0);
        send_request(FUNC_ALLOC, 16'd7, 16'd0);
        send_request(FUNC_ALLOC, 16'd40, 16'd0);
        send_request(FUNC_RELEASE, 16'd0, 16'd36);
        send_request(FUNC_RELEASE, 16'd0, 16'd36);
        send_request(FUNC_RELEASE, 16'd0, 16'd37);
        send_request(FUNC_RELEASE, 16'd0, 16'd204);
        send_request(FUNC_ALLOC, 16'd4, 16'd0);
        send_request(FUNC_RELEASE, 16'd0, 16'd72);
        send_request(FUNC_ALLOC, 16'hFFFF, 16'd0);
        send_request(FUNC_ALLOC, 16'hFFC0, 16'd0);
        send_request(FUNC_RELEASE, 16'd0, 16'hFFFF);
        write_reg(CFG_HEAP_LIMIT, 17'd0);
        send_request(FUNC_ALLOC, 16'd8, 16'd0);
        write_reg(CFG_HEAP_LIMIT, 17'h1FFFF);
        send_request(FUNC_ALLOC, 16'd8, 16'd0);
    endtask

    task automatic test_table_full();
        write_reg(CFG_FIT_MODE, 17'(FIT_FIRST));
        write_reg(CFG_HEAP_LIMIT, 17'd65536);
        for (int i = 0; i < 70; i++)
            send_request(FUNC_ALLOC, 16'($urandom_range(1, 12)), 16'($urandom));
        drain();
        for (int i = 0; i < 40; i++)
            send_request(FUNC_RELEASE, 16'($urandom), some_live_addr());
    endtask

    task automatic test_random(int n);
        logic [15:0] sz;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 48)
            begin
                sz = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
                send_request(FUNC_ALLOC, sz, 16'($urandom));
            end
            else if (k < 90)
                send_request(FUNC_RELEASE, 16'($urandom), some_live_addr());
            else if (k < 95)
                send_request(FUNC_RELEASE, 16'($urandom), 16'($urandom));
            else
                send_request(FUNC_RELEASE, 16'($urandom),
                             16'(some_live_addr() + $urandom_range(1, 3)));
            if (i == n / 2)
                drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        for (int i = 0; i < NB; i++)
            blk_used[i] = 1'b0;
        head_idx = NUL;
        tail_idx = NUL;
        rover_idx = NUL;
        top_bytes = 0;
        fit_sel = FIT_FIRST;
        limit_bytes = 65536;
        send_idle_pct = 25;
        recv_idle_pct = 67;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        for (int m = 0; m < 4; m++)
        begin
            write_reg(CFG_FIT_MODE, 17'(m));
            write_reg(CFG_HEAP_LIMIT, (m == 2) ? 17'd3000 : 17'd65536);
            if (m == 1)
            begin
                send_idle_pct = 67;
                recv_idle_pct = 25;
            end
            if (m == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            test_random(430);
        end
        drain();
        if (errors == 0)
            $display("** heap_block_allocator_core: PASSED **");
        else
            $display("** heap_block_allocator_core: FAILED **");
        $finish;
    end
endmodule
